// ===== hdl/dcps_pkg.sv =====
// Package for the drum channel program sequencer.
// Holds the shared codes, default parameter values and the state, configuration
// and result structs. It depends on nothing.
`timescale 1ns / 1ps

package dcps_pkg;

    // Default values for the top-level parameters.
    localparam int DEF_MEM_ADDR_BITS = 16;
    localparam int DEF_NUM_TRACKS    = 84;
    localparam int DEF_GAP_WORDS     = 236;

    // Fixed geometry and addresses.
    localparam int          SECTOR_WORDS = 2048;
    localparam logic [20:0] POS_ADDR     = 21'o21;
    localparam logic [23:0] DATA_FLAG    = 24'o40000;

    // Transaction actions.
    localparam logic [2:0] ACT_RESET   = 3'd0;
    localparam logic [2:0] ACT_START   = 3'd1;
    localparam logic [2:0] ACT_READPOS = 3'd2;
    localparam logic [2:0] ACT_STATUS  = 3'd3;
    localparam logic [2:0] ACT_SERVICE = 3'd4;

    // Channel program opcodes, bits 23..21 of a command word.
    localparam logic [2:0] OP_XFER      = 3'd0;
    localparam logic [2:0] OP_XFER_COND = 3'd1;
    localparam logic [2:0] OP_BRANCH    = 3'd2;
    localparam logic [2:0] OP_END       = 3'd4;
    localparam logic [2:0] OP_END_ERR   = 3'd5;
    localparam logic [2:0] OP_END_INT   = 3'd7;

    // Sequencer phases.
    localparam logic [1:0] PH_FETCH = 2'd0;
    localparam logic [1:0] PH_CORE  = 2'd1;
    localparam logic [1:0] PH_DRUM  = 2'd2;
    localparam logic [1:0] PH_XFER  = 2'd3;

    // Request codes.
    localparam logic [1:0] NREQ_IDLE  = 2'd0;
    localparam logic [1:0] NREQ_FETCH = 2'd1;
    localparam logic [1:0] NREQ_MEM   = 2'd2;
    localparam logic [1:0] NREQ_DRUM  = 2'd3;

    // Store targets.
    localparam logic [1:0] ST_NONE = 2'd0;
    localparam logic [1:0] ST_MEM  = 2'd1;
    localparam logic [1:0] ST_DRUM = 2'd2;

    // Interrupt changes.
    localparam logic [1:0] INT_NONE  = 2'd0;
    localparam logic [1:0] INT_RAISE = 2'd1;
    localparam logic [1:0] INT_CLEAR = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_FETCH_TIME    = 2'd0;
    localparam logic [1:0] CFG_WORD_TIME     = 2'd1;
    localparam logic [1:0] CFG_DRUM_ATTACHED = 2'd2;

    typedef struct packed {
        logic [1:0]  phase;
        logic        active;
        logic [15:0] pc;
        logic [15:0] core_ptr;
        logic [20:0] drum_ptr;
        logic [13:0] words_left;
        logic [11:0] parity;
        logic        write_mode;
        logic        error_flag;
    } t_state;

    typedef struct packed {
        logic [15:0] fetch_time;
        logic [7:0]  word_time;
        logic        drum_attached;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  next_request;
        logic [15:0] request_mem_address;
        logic [20:0] request_drum_address;
        logic [22:0] request_delay;
        logic [1:0]  store_target;
        logic [20:0] store_address;
        logic [23:0] store_word;
        logic [15:0] drum_pc;
        logic [1:0]  interrupt_change;
        logic        busy_res;
        logic        error;
        logic [11:0] parity;
    } t_result;

endpackage

// ===== hdl/dcps_step.sv =====
// Next-state and result logic for one transaction of the drum channel sequencer.
// Depends on dcps_pkg for codes and the state, configuration and result structs.
`timescale 1ns / 1ps

module dcps_step import dcps_pkg::*; #(
    parameter int MEM_ADDR_BITS = DEF_MEM_ADDR_BITS,
    parameter int NUM_TRACKS    = DEF_NUM_TRACKS,
    parameter int GAP_WORDS     = DEF_GAP_WORDS
) (
    input  t_state      i_state,
    input  t_cfg        i_cfg,
    input  logic [2:0]  i_action,
    input  logic [23:0] i_data_word,
    input  logic [14:0] i_drum_position,
    output t_state      o_state,
    output t_result     o_result
);

    localparam logic [15:0] AMASK      = 16'((32'd1 << MEM_ADDR_BITS) - 32'd1);
    localparam logic [14:0] REV_WORDS  = 15'(8 * (SECTOR_WORDS + GAP_WORDS));
    localparam logic [14:0] GAP_W      = 15'(GAP_WORDS);
    localparam logic [14:0] SECTOR_W   = 15'(SECTOR_WORDS);
    localparam logic [21:0] DRUM_WORDS = 22'(NUM_TRACKS * 8 * SECTOR_WORDS);

    localparam logic [1:0] K_NONE = 2'd0;
    localparam logic [1:0] K_PROG = 2'd1;
    localparam logic [1:0] K_XFER = 2'd2;

    logic [12:0] gap_tab [8];
    logic [14:0] pos_mod;
    logic [23:0] pos_word;
    logic [14:0] rda;
    logic [14:0] rot_t;
    logic [20:0] dp_inc;
    logic [20:0] dp_next;
    logic [13:0] wl_dec;
    logic [11:0] par_mix;
    logic [11:0] par_next;
    logic [15:0] pc_inc;
    logic [2:0]  opcode;
    logic [14:0] mul_a;
    logic [22:0] product;
    logic [22:0] delay;
    logic [1:0]  kind;
    t_state      n;
    t_result     res;

    // Sector start offsets caused by the inter-sector gaps.
    always_comb begin
        for (int k = 0; k < 8; k++) begin
            gap_tab[k] = 13'(k * GAP_WORDS);
        end
    end

    // The position input is below twice a revolution, so one subtract reduces it.
    assign pos_mod  = (i_drum_position >= REV_WORDS) ? i_drum_position - REV_WORDS
                                                     : i_drum_position;
    assign pos_word = (pos_mod < GAP_W) ? 24'(SECTOR_W - pos_mod)
                                        : (24'(pos_mod - GAP_W) | DATA_FLAG);

    // Rotational position of the target drum address, gaps included.
    assign rda   = 15'(i_data_word[13:0]) + 15'(gap_tab[i_data_word[13:11]]);
    assign rot_t = (rda > pos_mod) ? rda - pos_mod
                                   : 15'(16'(rda) + 16'(REV_WORDS) - 16'(pos_mod));

    assign dp_inc   = i_state.drum_ptr + 21'd1;
    assign dp_next  = ({1'b0, dp_inc} >= DRUM_WORDS) ? '0 : dp_inc;
    assign wl_dec   = i_state.words_left - 14'd1;
    assign par_mix  = i_state.parity ^ i_data_word[23:12];
    assign par_next = {par_mix[10:0], par_mix[11]} ^ i_data_word[11:0];
    assign pc_inc   = (i_state.pc + 16'd1) & AMASK;
    assign opcode   = i_data_word[23:21];

    always_comb begin
        n     = i_state;
        res   = '0;
        kind  = K_NONE;
        mul_a = 15'd1;
        unique case (i_action)
            ACT_RESET: begin
                n       = '0;
                n.pc    = i_state.pc;
                res.interrupt_change = INT_CLEAR;
            end
            ACT_START: begin
                if (!i_state.active) begin
                    n.phase  = PH_FETCH;
                    n.active = 1'b1;
                    n.pc     = i_data_word[15:0] & AMASK;
                    kind     = K_PROG;
                end
            end
            ACT_READPOS: begin
                if (!i_state.active) begin
                    res.store_target  = ST_MEM;
                    res.store_address = POS_ADDR;
                    res.store_word    = pos_word;
                end
            end
            ACT_SERVICE: begin
                if (i_state.active) begin
                    if (i_state.phase != PH_XFER) begin
                        n.pc = pc_inc;
                        kind = K_PROG;
                        unique case (i_state.phase)
                            PH_CORE: begin
                                n.write_mode = i_data_word[20];
                                n.core_ptr   = i_data_word[15:0] & AMASK;
                                n.phase      = PH_DRUM;
                            end
                            PH_DRUM: begin
                                n.drum_ptr = i_data_word[20:0];
                                n.phase    = PH_XFER;
                                n.parity   = '0;
                                kind       = K_XFER;
                                mul_a      = rot_t;
                            end
                            default: begin
                                // Command fetch.
                                if (opcode == OP_XFER_COND && i_state.error_flag) begin
                                    res.interrupt_change = INT_RAISE;
                                    n.active = 1'b0;
                                    kind     = K_NONE;
                                end else if (opcode == OP_XFER || opcode == OP_XFER_COND) begin
                                    n.words_left = i_data_word[13:0];
                                    n.phase      = PH_CORE;
                                end else if (opcode == OP_BRANCH) begin
                                    n.pc = i_data_word[15:0] & AMASK;
                                end else if (opcode == OP_END) begin
                                    n.active = 1'b0;
                                    kind     = K_NONE;
                                end else if (opcode == OP_END_ERR || opcode == OP_END_INT) begin
                                    if (opcode == OP_END_INT || i_state.error_flag) begin
                                        res.interrupt_change = INT_RAISE;
                                    end
                                    n.active = 1'b0;
                                    kind     = K_NONE;
                                end
                            end
                        endcase
                    end else if (!i_cfg.drum_attached) begin
                        n.error_flag = 1'b1;
                        n.active     = 1'b0;
                    end else begin
                        if (i_state.write_mode) begin
                            res.store_target  = ST_DRUM;
                            res.store_address = i_state.drum_ptr;
                        end else begin
                            res.store_target  = ST_MEM;
                            res.store_address = 21'(i_state.core_ptr);
                        end
                        res.store_word = i_data_word;
                        n.drum_ptr     = dp_next;
                        n.core_ptr     = (i_state.core_ptr + 16'd1) & AMASK;
                        n.words_left   = wl_dec;
                        n.parity       = par_next;
                        if (wl_dec != '0) begin
                            kind  = K_XFER;
                            mul_a = (dp_next[10:0] != '0) ? 15'd1 : GAP_W;
                        end else begin
                            n.phase = PH_FETCH;
                            kind    = K_PROG;
                        end
                    end
                end
            end
            default: begin
                // Status query and unused actions change nothing.
            end
        endcase
    end

    // One shared multiplier serves both the rotational and the per-word delays.
    assign product = 23'(mul_a) * 23'(i_cfg.word_time);

    always_comb begin
        unique case (kind)
            K_PROG:  delay = 23'(i_cfg.fetch_time);
            K_XFER:  delay = product;
            default: delay = '0;
        endcase
    end

    always_comb begin
        o_result = res;
        unique case (kind)
            K_PROG: begin
                o_result.next_request        = NREQ_FETCH;
                o_result.request_mem_address = n.pc;
                o_result.request_delay       = delay;
            end
            K_XFER: begin
                o_result.next_request         = n.write_mode ? NREQ_MEM : NREQ_DRUM;
                o_result.request_mem_address  = n.core_ptr;
                o_result.request_drum_address = n.drum_ptr;
                o_result.request_delay        = delay;
            end
            default: begin
                o_result.next_request = NREQ_IDLE;
            end
        endcase
        o_result.drum_pc  = n.pc;
        o_result.busy_res = n.active;
        o_result.error    = n.error_flag;
        o_result.parity   = n.parity;
    end

    assign o_state = n;

endmodule

// ===== hdl/drum_channel_program_sequencer_unit.sv =====
// Top level of the drum channel program sequencer: handshakes, configuration
// registers, sequencer state and the result register. Depends on dcps_pkg and dcps_step.
`timescale 1ns / 1ps

// Channel   | Handshake                 | Payload
// ----------+---------------------------+------------------------------------------
// input     | i_in_valid / o_in_ready   | i_action, i_data_word, i_drum_position
// result    | o_out_valid / i_out_ready | o_next_request ... o_parity (12 fields)
// config    | i_cfg_we (no wait)        | i_cfg_index, i_cfg_data
//
// Every input transaction produces exactly one result transaction. It waits in the
// input register, then passes the decode and a single 15x8 delay multiplier in front
// of the result register. The sequencer state is updated in the same cycle the result
// is registered, so one transaction per cycle is sustained while the result channel
// does not stall. Reset is synchronous and active low; it clears the pipeline valids,
// the channel state and loads the configuration defaults. A stalled result holds
// the result register, which in turn holds the input register and drops o_in_ready.

module drum_channel_program_sequencer_unit import dcps_pkg::*; #(
    parameter int MEM_ADDR_BITS = DEF_MEM_ADDR_BITS,
    parameter int NUM_TRACKS    = DEF_NUM_TRACKS,
    parameter int GAP_WORDS     = DEF_GAP_WORDS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input channel.
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_action,
    input  logic [23:0] i_data_word,
    input  logic [14:0] i_drum_position,
    // Result channel.
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_next_request,
    output logic [15:0] o_request_mem_address,
    output logic [20:0] o_request_drum_address,
    output logic [22:0] o_request_delay,
    output logic [1:0]  o_store_target,
    output logic [20:0] o_store_address,
    output logic [23:0] o_store_word,
    output logic [15:0] o_drum_pc,
    output logic [1:0]  o_interrupt_change,
    output logic        o_busy_res,
    output logic        o_error,
    output logic [11:0] o_parity,
    // Configuration write port.
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic        r_in_valid;
    logic [2:0]  r_action;
    logic [23:0] r_data_word;
    logic [14:0] r_drum_position;
    logic        r_out_valid;
    t_result     r_res;
    t_state      r_state;
    t_cfg        r_cfg;

    t_state      n_state;
    t_result     n_res;
    logic        s_move;

    // The held transaction moves into the result register whenever that register
    // is empty or is being drained in this cycle.
    assign s_move     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || s_move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_action        <= i_action;
            r_data_word     <= i_data_word;
            r_drum_position <= i_drum_position;
        end
    end

    // Configuration is to be written only while the channel is idle, so the step logic
    // may read these registers directly; the block itself does not enforce this.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fetch_time    <= 16'd3;
            r_cfg.word_time     <= 8'd1;
            r_cfg.drum_attached <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FETCH_TIME:    r_cfg.fetch_time    <= i_cfg_data;
                CFG_WORD_TIME:     r_cfg.word_time     <= i_cfg_data[7:0];
                CFG_DRUM_ATTACHED: r_cfg.drum_attached <= i_cfg_data[0];
                default: begin
                    // Writes past the register list are dropped.
                end
            endcase
        end
    end

    dcps_step #(
        .MEM_ADDR_BITS (MEM_ADDR_BITS),
        .NUM_TRACKS    (NUM_TRACKS),
        .GAP_WORDS     (GAP_WORDS)
    ) u_step (
        .i_state         (r_state),
        .i_cfg           (r_cfg),
        .i_action        (r_action),
        .i_data_word     (r_data_word),
        .i_drum_position (r_drum_position),
        .o_state         (n_state),
        .o_result        (n_res)
    );

    // The channel state advances exactly once per transaction, together with the
    // registration of its result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (s_move) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_move) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_move) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid            = r_out_valid;
    assign o_next_request         = r_res.next_request;
    assign o_request_mem_address  = r_res.request_mem_address;
    assign o_request_drum_address = r_res.request_drum_address;
    assign o_request_delay        = r_res.request_delay;
    assign o_store_target         = r_res.store_target;
    assign o_store_address        = r_res.store_address;
    assign o_store_word           = r_res.store_word;
    assign o_drum_pc              = r_res.drum_pc;
    assign o_interrupt_change     = r_res.interrupt_change;
    assign o_busy_res             = r_res.busy_res;
    assign o_error                = r_res.error;
    assign o_parity               = r_res.parity;

    // A freshly registered result reports the state it left behind.
    a_result_tracks_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_move |=> (o_busy_res == r_state.active) && (o_error == r_state.error_flag)
                   && (o_parity == r_state.parity) && (o_drum_pc == r_state.pc))
        else $error("result status does not match channel state");

    // Without a request, the request fields stay zero.
    a_idle_request_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_next_request == NREQ_IDLE) |->
            (o_request_delay == '0) && (o_request_mem_address == '0)
            && (o_request_drum_address == '0))
        else $error("request fields set without a request");

    // Without a store, the store fields stay zero.
    a_idle_store_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_store_target == ST_NONE) |->
            (o_store_address == '0) && (o_store_word == '0))
        else $error("store fields set without a store");

    // The state only changes when a transaction completes its pass.
    a_state_only_on_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!s_move && i_rst_n) |=> $stable(r_state))
        else $error("channel state changed without a transaction");

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for drum_channel_program_sequencer_unit: random and directed
// channel programs through the input handshake, with an in-bench predictor of the sequencer.
// Depends on dcps_pkg and the unit's RTL only.
`timescale 1ns / 1ps

module tb;
    import dcps_pkg::*;

    // Drum geometry at the default parameters of the unit.
    localparam int GAP       = DEF_GAP_WORDS;
    localparam int REV       = 8 * (SECTOR_WORDS + GAP);
    localparam int DRUM_SIZE = DEF_NUM_TRACKS * 8 * SECTOR_WORDS;

    // Opcodes that only advance the program, and the register index with no register.
    localparam logic [2:0] OP_FILLER_3 = 3'd3;
    localparam logic [2:0] OP_FILLER_6 = 3'd6;
    localparam logic [1:0] CFG_UNUSED  = 2'd3;

    typedef struct packed {
        logic [2:0]  action;
        logic [23:0] data;
        logic [14:0] pos;
    } t_item;

    // What a service asks for next, before it is turned into a request code.
    typedef enum logic [1:0] {ASK_NONE, ASK_PROGRAM, ASK_DATA} t_ask;

    // Every input of the unit starts at a known value.
    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_in_valid      = 1'b0;
    logic [2:0]  i_action        = ACT_STATUS;
    logic [23:0] i_data_word     = '0;
    logic [14:0] i_drum_position = '0;
    logic        i_out_ready     = 1'b0;
    logic        i_cfg_we        = 1'b0;
    logic [1:0]  i_cfg_index     = CFG_FETCH_TIME;
    logic [15:0] i_cfg_data      = '0;

    logic        o_in_ready;
    logic        o_out_valid;
    logic [1:0]  o_next_request;
    logic [15:0] o_request_mem_address;
    logic [20:0] o_request_drum_address;
    logic [22:0] o_request_delay;
    logic [1:0]  o_store_target;
    logic [20:0] o_store_address;
    logic [23:0] o_store_word;
    logic [15:0] o_drum_pc;
    logic [1:0]  o_interrupt_change;
    logic        o_busy_res;
    logic        o_error;
    logic [11:0] o_parity;

    drum_channel_program_sequencer_unit u_dut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_in_valid             (i_in_valid),
        .o_in_ready             (o_in_ready),
        .i_action               (i_action),
        .i_data_word            (i_data_word),
        .i_drum_position        (i_drum_position),
        .o_out_valid            (o_out_valid),
        .i_out_ready            (i_out_ready),
        .o_next_request         (o_next_request),
        .o_request_mem_address  (o_request_mem_address),
        .o_request_drum_address (o_request_drum_address),
        .o_request_delay        (o_request_delay),
        .o_store_target         (o_store_target),
        .o_store_address        (o_store_address),
        .o_store_word           (o_store_word),
        .o_drum_pc              (o_drum_pc),
        .o_interrupt_change     (o_interrupt_change),
        .o_busy_res             (o_busy_res),
        .o_error                (o_error),
        .o_parity               (o_parity),
        .i_cfg_we               (i_cfg_we),
        .i_cfg_index            (i_cfg_index),
        .i_cfg_data             (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predicted channel state and configuration, kept in step with the unit.
    // ------------------------------------------------------------------
    logic [1:0]  ch_phase;
    logic        ch_active;
    logic [15:0] ch_pc;
    logic [15:0] ch_core;
    logic [20:0] ch_drum;
    logic [13:0] ch_left;
    logic [11:0] ch_par;
    logic        ch_wr;
    logic        ch_err;
    logic [15:0] cf_fetch;
    logic [7:0]  cf_word;
    logic        cf_attached;

    // Stimulus waiting for the driver, and results waiting for the unit.
    t_item   pending_items[$];
    t_result expected_results[$];

    // Counters. Each one is written at one clock edge only, so readers at the
    // other edge never race with an update.
    int pushed_total   = 0;
    int accepted_total = 0;
    int results_total  = 0;
    int mismatch_count = 0;

    string field_names [12] = '{"next_request", "request_mem_address",
        "request_drum_address", "request_delay", "store_target", "store_address",
        "store_word", "drum_pc", "interrupt_change", "busy_res", "error", "parity"};

    function automatic void clear_channel_state();
        ch_phase  = PH_FETCH;
        ch_active = 1'b0;
        ch_core   = '0;
        ch_drum   = '0;
        ch_left   = '0;
        ch_par    = '0;
        ch_wr     = 1'b0;
        ch_err    = 1'b0;
    endfunction

    // Advances the predicted channel by one transaction and returns the result
    // that the unit has to produce for it.
    function automatic t_result sequence_channel(input logic [2:0] act,
                                                 input logic [23:0] dw,
                                                 input logic [14:0] pos);
        t_result     r;
        t_ask        ask;
        int unsigned delay;
        int unsigned p;
        int          t;
        logic [2:0]  op;
        r     = '0;
        ask   = ASK_NONE;
        delay = 0;
        p     = int'(pos) % REV;
        case (act)
            ACT_RESET: begin
                // The program counter survives a channel reset.
                clear_channel_state();
                r.interrupt_change = INT_CLEAR;
            end
            ACT_START: begin
                if (!ch_active) begin
                    ch_phase  = PH_FETCH;
                    ch_active = 1'b1;
                    ch_pc     = dw[15:0];
                    ask       = ASK_PROGRAM;
                    delay     = cf_fetch;
                end
            end
            ACT_READPOS: begin
                // Inside the gap the count down to the sector start is stored,
                // otherwise the word position with the data flag set.
                if (!ch_active) begin
                    r.store_target  = ST_MEM;
                    r.store_address = POS_ADDR;
                    r.store_word    = (p < GAP) ? 24'(SECTOR_WORDS - p)
                                                : (24'(p - GAP) | DATA_FLAG);
                end
            end
            ACT_SERVICE: begin
                if (!ch_active) begin
                    // A service with the channel stopped changes nothing.
                end else if (ch_phase != PH_XFER) begin
                    ch_pc = ch_pc + 16'd1;
                    ask   = ASK_PROGRAM;
                    delay = cf_fetch;
                    if (ch_phase == PH_CORE) begin
                        ch_wr    = dw[20];
                        ch_core  = dw[15:0];
                        ch_phase = PH_DRUM;
                    end else if (ch_phase == PH_DRUM) begin
                        // Wait for the target word to come around under the head.
                        ch_drum  = dw[20:0];
                        ch_phase = PH_XFER;
                        ch_par   = '0;
                        ask      = ASK_DATA;
                        t = int'(ch_drum[13:0]) + int'(ch_drum[13:11]) * GAP - int'(p);
                        if (t <= 0)
                            t = t + REV;
                        delay = t * cf_word;
                    end else begin
                        op = dw[23:21];
                        if (op == OP_XFER_COND && ch_err) begin
                            r.interrupt_change = INT_RAISE;
                            ch_active = 1'b0;
                            ask = ASK_NONE;
                        end else if (op == OP_XFER || op == OP_XFER_COND) begin
                            ch_left  = dw[13:0];
                            ch_phase = PH_CORE;
                        end else if (op == OP_BRANCH) begin
                            ch_pc = dw[15:0];
                        end else if (op == OP_END) begin
                            ch_active = 1'b0;
                            ask = ASK_NONE;
                        end else if (op == OP_END_ERR || op == OP_END_INT) begin
                            if (op == OP_END_INT || ch_err)
                                r.interrupt_change = INT_RAISE;
                            ch_active = 1'b0;
                            ask = ASK_NONE;
                        end
                    end
                end else if (!cf_attached) begin
                    // No drum behind the channel: flag the error and stop.
                    ch_err    = 1'b1;
                    ch_active = 1'b0;
                end else begin
                    r.store_target  = ch_wr ? ST_DRUM : ST_MEM;
                    r.store_address = ch_wr ? ch_drum : 21'(ch_core);
                    r.store_word    = dw;
                    ch_drum = ch_drum + 21'd1;
                    if (ch_drum >= DRUM_SIZE)
                        ch_drum = '0;
                    ch_core = ch_core + 16'd1;
                    ch_left = ch_left - 14'd1;
                    // Fold in the high half, rotate left by one, fold in the low half.
                    ch_par = ch_par ^ dw[23:12];
                    ch_par = {ch_par[10:0], ch_par[11]};
                    ch_par = ch_par ^ dw[11:0];
                    if (ch_left != 0) begin
                        ask   = ASK_DATA;
                        delay = (ch_drum[10:0] != 0) ? cf_word : cf_word * GAP;
                    end else begin
                        ch_phase = PH_FETCH;
                        ask      = ASK_PROGRAM;
                        delay    = cf_fetch;
                    end
                end
            end
            default: begin
                // Status queries and unknown actions only report the state.
            end
        endcase
        if (ask == ASK_PROGRAM) begin
            r.next_request        = NREQ_FETCH;
            r.request_mem_address = ch_pc;
            r.request_delay       = 23'(delay);
        end else if (ask == ASK_DATA) begin
            r.next_request         = ch_wr ? NREQ_MEM : NREQ_DRUM;
            r.request_mem_address  = ch_core;
            r.request_drum_address = ch_drum;
            r.request_delay        = 23'(delay);
        end
        r.drum_pc  = ch_pc;
        r.busy_res = ch_active;
        r.error    = ch_err;
        r.parity   = ch_par;
        return r;
    endfunction

    function automatic logic [23:0] field_value(input t_result r, input int k);
        case (k)
            0:       return 24'(r.next_request);
            1:       return 24'(r.request_mem_address);
            2:       return 24'(r.request_drum_address);
            3:       return 24'(r.request_delay);
            4:       return 24'(r.store_target);
            5:       return 24'(r.store_address);
            6:       return r.store_word;
            7:       return 24'(r.drum_pc);
            8:       return 24'(r.interrupt_change);
            9:       return 24'(r.busy_res);
            10:      return 24'(r.error);
            default: return 24'(r.parity);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Monitor: samples both handshakes and the configuration port at the
    // rising edge, checks results and predicts every accepted transaction.
    // ------------------------------------------------------------------
    t_result got_result;
    t_result want_result;
    bit      in_taken = 1'b0;
    bit      field_err;
    int      fk;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_channel_state();
            ch_pc       = '0;
            cf_fetch    = 16'd3;
            cf_word     = 8'd1;
            cf_attached = 1'b0;
            in_taken   <= 1'b0;
        end else begin
            in_taken <= i_in_valid && o_in_ready;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_FETCH_TIME:    cf_fetch    = i_cfg_data;
                    CFG_WORD_TIME:     cf_word     = i_cfg_data[7:0];
                    CFG_DRUM_ATTACHED: cf_attached = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (o_out_valid && i_out_ready) begin
                results_total++;
                got_result = {o_next_request, o_request_mem_address, o_request_drum_address,
                              o_request_delay, o_store_target, o_store_address, o_store_word,
                              o_drum_pc, o_interrupt_change, o_busy_res, o_error, o_parity};
                if (expected_results.size() == 0) begin
                    $display("%0t: result transaction with none expected, got %h",
                             $time, got_result);
                    mismatch_count++;
                end else begin
                    want_result = expected_results.pop_front();
                    field_err = 1'b0;
                    for (fk = 0; fk < 12; fk++) begin
                        if (field_value(got_result, fk) !== field_value(want_result, fk)) begin
                            $display("%0t: %s expected %0h got %0h", $time, field_names[fk],
                                     field_value(want_result, fk),
                                     field_value(got_result, fk));
                            field_err = 1'b1;
                        end
                    end
                    if (field_err)
                        mismatch_count++;
                end
            end
            if (i_in_valid && o_in_ready) begin
                expected_results.push_back(
                    sequence_channel(i_action, i_data_word, i_drum_position));
                accepted_total++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver: offers queued transactions in bursts of random length with
    // random gaps. A payload is held until its transaction is taken.
    // ------------------------------------------------------------------
    t_item next_item;
    int    gap_left   = 0;
    int    burst_left = 1;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (gap_left != 0) begin
                gap_left   <= gap_left - 1;
                i_in_valid <= 1'b0;
            end else if (pending_items.size() != 0) begin
                next_item        = pending_items.pop_front();
                i_action        <= next_item.action;
                i_data_word     <= next_item.data;
                i_drum_position <= next_item.pos;
                i_in_valid      <= 1'b1;
                if (burst_left <= 1) begin
                    // Now and then a long burst with no idle cycles at all.
                    burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                              : $urandom_range(1, 24);
                    gap_left   <= $urandom_range(0, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stalls on a pattern that switches between always ready,
    // coin flips, a rotating mask and heavy back-pressure. After 200 results and then
    // every 450 more it holds off, so the pipeline fills and drops o_in_ready.
    // ------------------------------------------------------------------
    int          hold_left     = 0;
    int          next_hold     = 200;
    int          mode_left     = 0;
    int          stall_mode    = 0;
    logic [15:0] stall_pattern = 16'b1011_0111_0010_1101;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (results_total >= next_hold) begin
            hold_left   <= 100;
            next_hold   <= next_hold + 450;
            i_out_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                stall_mode <= $urandom_range(0, 3);
                mode_left  <= $urandom_range(16, 96);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (stall_mode)
                0:       i_out_ready <= 1'b1;
                1:       i_out_ready <= 1'($urandom_range(0, 1));
                2:       i_out_ready <= stall_pattern[0];
                default: i_out_ready <= ($urandom_range(0, 7) == 0);
            endcase
            stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
        end
    end

    // ------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------
    function automatic logic [14:0] rnd_pos();
        // Mostly within one revolution, sometimes anywhere in the 15-bit field.
        return ($urandom_range(0, 7) == 0) ? 15'($urandom) : 15'($urandom_range(0, REV - 1));
    endfunction

    task automatic queue_item(input logic [2:0] act, input logic [23:0] dw,
                              input logic [14:0] pos);
        t_item it;
        it.action = act;
        it.data   = dw;
        it.pos    = pos;
        pending_items.push_back(it);
        pushed_total++;
    endtask

    // Occasionally slips a stray transaction into a program; a channel reset
    // breaks the program off, and the services after it are ignored unless a stray start follows.
    task automatic sprinkle_noise();
        if ($urandom_range(0, 15) == 0) begin
            case ($urandom_range(0, 5))
                0:       queue_item(ACT_RESET, 24'($urandom), rnd_pos());
                1:       queue_item(ACT_START, 24'($urandom), rnd_pos());
                2:       queue_item(ACT_READPOS, 24'($urandom), rnd_pos());
                3:       queue_item(3'($urandom_range(ACT_SERVICE + 1, 7)), 24'($urandom),
                                    rnd_pos());
                default: queue_item(ACT_STATUS, 24'($urandom), rnd_pos());
            endcase
        end
    endtask

    task automatic queue_service(input logic [23:0] dw);
        sprinkle_noise();
        queue_item(ACT_SERVICE, dw, rnd_pos());
    endtask

    // One well-formed channel program with random content: start, a few
    // commands with their address words and data, and an end command.
    task automatic queue_program();
        int          n_cmd;
        int          wc;
        int          k;
        int          j;
        int          r;
        logic [2:0]  op;
        logic [20:0] da;
        queue_item(ACT_START, ($urandom_range(0, 15) == 0) ? 24'hFFFFFF : 24'($urandom),
                   rnd_pos());
        n_cmd = $urandom_range(1, 4);
        for (k = 0; k < n_cmd; k++) begin
            case ($urandom_range(0, 9))
                0:       op = OP_BRANCH;
                1:       op = $urandom_range(0, 1) ? OP_FILLER_3 : OP_FILLER_6;
                default: op = $urandom_range(0, 1) ? OP_XFER : OP_XFER_COND;
            endcase
            if (op != OP_XFER && op != OP_XFER_COND) begin
                queue_service({op, 21'($urandom)});
            end else begin
                r  = $urandom_range(0, 9);
                wc = (r < 7) ? $urandom_range(1, 3) : (r < 9) ? $urandom_range(4, 12)
                                                           : $urandom_range(13, 40);
                queue_service({op, 7'($urandom), 14'(wc)});
                queue_service(24'($urandom));
                case ($urandom_range(0, 5))
                    0:       da = 21'(DRUM_SIZE - $urandom_range(1, 4));
                    1:       da = (21'($urandom) & 21'h1FF800)
                                  | (21'h7FF - 21'($urandom_range(0, 2)));
                    2:       da = 21'($urandom);
                    default: da = 21'($urandom_range(0, DRUM_SIZE - 1));
                endcase
                queue_service({3'($urandom), da});
                for (j = 0; j < wc; j++)
                    queue_service(24'($urandom));
            end
        end
        case ($urandom_range(0, 2))
            0:       op = OP_END;
            1:       op = OP_END_ERR;
            default: op = OP_END_INT;
        endcase
        queue_service({op, 21'($urandom)});
        // Position reads and stray services between programs, with the channel idle.
        if ($urandom_range(0, 2) == 0)
            queue_item(ACT_READPOS, 24'($urandom), rnd_pos());
        if ($urandom_range(0, 7) == 0)
            queue_item(ACT_SERVICE, 24'($urandom), rnd_pos());
    endtask

    task automatic queue_random(input int count);
        int target;
        target = pushed_total + count;
        while (pushed_total < target)
            queue_program();
    endtask

    // Waits until every queued transaction is taken and answered, then lets the
    // two-stage pipeline settle.
    task automatic wait_drained(input int settle);
        while (accepted_total != pushed_total || results_total < accepted_total)
            @(negedge i_clk);
        repeat (settle) @(negedge i_clk);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [15:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Registers change only with the unit idle. Unused upper bits of the data
    // are filled at random, and the index with no register is written too.
    task automatic configure(input logic [15:0] fetch, input logic [7:0] word,
                             input logic attached);
        wait_drained(4);
        write_cfg(CFG_FETCH_TIME, fetch);
        write_cfg(CFG_WORD_TIME, {8'($urandom), word});
        write_cfg(CFG_DRUM_ATTACHED, {15'($urandom), attached});
        write_cfg(CFG_UNUSED, 16'($urandom));
        @(posedge i_clk);
    endtask

    int a;

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at the reset configuration, with no drum attached.
        queue_item(ACT_RESET, 24'hFFFFFF, 15'h7FFF);
        queue_item(ACT_READPOS, 24'h000000, 15'd0);
        queue_item(ACT_READPOS, 24'hFFFFFF, 15'(GAP - 1));
        queue_item(ACT_READPOS, 24'h000000, 15'(GAP));
        queue_item(ACT_READPOS, 24'h000000, 15'(REV - 1));
        queue_item(ACT_READPOS, 24'h000000, 15'h7FFF);
        queue_item(ACT_SERVICE, 24'($urandom), rnd_pos());
        for (a = ACT_SERVICE + 1; a <= 7; a++)
            queue_item(3'(a), 24'($urandom), rnd_pos());
        // Start with an all-ones pointer, then a second start and a position
        // read that the running channel ignores.
        queue_item(ACT_START, 24'hFFFFFF, 15'd0);
        queue_item(ACT_START, 24'h000123, 15'd0);
        queue_item(ACT_READPOS, 24'h000000, 15'd100);
        queue_item(ACT_SERVICE, {OP_FILLER_3, 21'($urandom)}, 15'd0);
        queue_item(ACT_SERVICE, {OP_FILLER_6, 21'($urandom)}, 15'd0);
        queue_item(ACT_SERVICE, {OP_BRANCH, 21'h001234}, 15'd0);
        // A transfer with no drum: the first data word sets the error flag.
        queue_item(ACT_SERVICE, {OP_XFER, 21'd2}, 15'd0);
        queue_item(ACT_SERVICE, 24'h1FFFFF, 15'd0);
        queue_item(ACT_SERVICE, 24'h1FFFFF, 15'd0);
        queue_item(ACT_SERVICE, 24'hABCDEF, 15'd0);
        // With the error set, a conditional transfer and an end-on-error interrupt.
        queue_item(ACT_START, 24'h000040, 15'd0);
        queue_item(ACT_SERVICE, {OP_XFER_COND, 21'd5}, 15'd0);
        queue_item(ACT_START, 24'h000050, 15'd0);
        queue_item(ACT_SERVICE, {OP_END_ERR, 21'd0}, 15'd0);
        // After a channel reset the same end command stays quiet.
        queue_item(ACT_RESET, 24'h000000, 15'd0);
        queue_item(ACT_START, 24'h000060, 15'd0);
        queue_item(ACT_SERVICE, {OP_END_ERR, 21'd0}, 15'd0);
        queue_item(ACT_START, 24'h000070, 15'd0);
        queue_item(ACT_SERVICE, {OP_END_INT, 21'd0}, 15'd0);
        queue_item(ACT_START, 24'h000080, 15'd0);
        queue_item(ACT_SERVICE, {OP_END, 21'd0}, 15'd0);

        // Drum attached. A zero word count wraps to its maximum,
        // and the drum address runs off the end of the drum and back to zero.
        configure(16'd1, 8'd1, 1'b1);
        queue_item(ACT_START, 24'h000100, 15'd0);
        queue_item(ACT_SERVICE, {OP_XFER_COND, 21'd0}, 15'd0);
        queue_item(ACT_SERVICE, 24'h004000, 15'd0);
        queue_item(ACT_SERVICE, 24'(DRUM_SIZE - 2), 15'd5000);
        queue_item(ACT_SERVICE, 24'($urandom), 15'd0);
        queue_item(ACT_SERVICE, 24'($urandom), 15'd0);
        queue_item(ACT_SERVICE, 24'($urandom), 15'd0);
        queue_item(ACT_RESET, 24'h000000, 15'd0);
        queue_random(300);

        configure(16'hFFFF, 8'hFF, 1'b1);
        queue_random(250);
        configure(16'd0, 8'd0, 1'b1);
        queue_random(200);
        configure(16'($urandom_range(1, 65535)), 8'($urandom_range(1, 255)), 1'b1);
        queue_random(400);
        configure(16'($urandom_range(1, 200)), 8'($urandom_range(1, 255)), 1'b0);
        queue_random(200);
        configure(16'd3, 8'd1, 1'b1);
        queue_random(250);

        wait_drained(8);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog far beyond the slowest legal run.
    initial begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
